>>> rtl/tstr_pkg.sv
// Shared types, sizes and helper functions of the time-sorted task ring.
package tstr_pkg;

    localparam int DEPTH   = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int KEY_W   = 11;
    localparam int ENTRY_W = 30;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TAKE   = 2'd1,
        OP_ROTATE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] command;
        logic [2:0]  level;
    } entry_t;

    typedef struct packed {
        op_t         op;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] command_id;
        logic [2:0]  log_level;
    } req_word_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  task_hour;
        logic [5:0]  task_minute;
        logic [15:0] task_command;
        logic [2:0]  task_level;
    } rsp_word_t;

    // Physical slot of a position counted from a ring base; the sum stays below twice DEPTH.
    function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] entry_key(entry_t e);
        return {e.hour, e.minute};
    endfunction

endpackage

>>> rtl/tstr_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module tstr_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 30
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/time_sorted_task_ring.sv
// Top level of the time-sorted task ring: sequencer, ring pointers and result register.
// Sequence: a take and a dropped insert go through head read, head check and output; on an
// empty ring a take or rotate goes straight to output; rotate repeats head read and check per entry moved.
// Insert reads and compares per entry scanned, reads and writes per entry shifted, writes the task,
// then reads and checks the head. One request word at a time, stalled until the sequencer is back in idle.
// Reset: head index and entry count clear to zero; the entry RAM is not cleared.
module time_sorted_task_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  tstr_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tstr_pkg::rsp_word_t rsp
);

    import tstr_pkg::*;

    // Control state.
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;     // scan position, also the insert slot
    logic [CNT_W-1:0] idx_reg, idx_next;     // shift cursor, walks from the tail down
    logic [CNT_W-1:0] pops_reg, pops_next;   // number of takes done by a rotate
    logic             rsp_valid_reg, rsp_valid_next;

    // Payload state of the word in progress and of the result.
    op_t              op_reg, op_next;
    status_t          stat_reg, stat_next;
    logic [KEY_W-1:0] key_reg, key_next;
    entry_t           new_reg, new_next;
    rsp_word_t        res_reg, res_next;
    rsp_word_t        rsp_reg, rsp_next;

    // Entry RAM access.
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    entry_t           rd_entry;

    logic             accept;
    logic             rsp_free;
    logic             take_now;

    assign rd_entry  = entry_t'(mem_rdata);
    assign accept    = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A rotate with two or more entries always takes once, then keeps taking while the head is earlier than the
    // given time, and never takes more than one full circle.
    assign take_now = (count_reg >= CNT_W'(2)) &&
                      ((pops_reg == '0) ||
                       ((pops_reg < count_reg) && (entry_key(rd_entry) < key_reg)));

    tstr_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (ENTRY_W'(mem_wdata)),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.op == OP_INSERT)
                    begin
                        // A full ring drops the task and only reports the head.
                        state_next = (count_reg == CNT_W'(DEPTH)) ? S_HEAD_RD : S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? S_OUT : S_HEAD_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = (pos_reg == count_reg) ? S_SHIFT_RD : S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                state_next = (key_reg > entry_key(rd_entry)) ? S_SCAN_RD : S_SHIFT_RD;
            end
            S_SHIFT_RD:
            begin
                state_next = (idx_reg > pos_reg) ? S_SHIFT_WR : S_INS_WR;
            end
            S_SHIFT_WR:
            begin
                state_next = S_SHIFT_RD;
            end
            S_INS_WR:
            begin
                state_next = S_HEAD_RD;
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_CHK;
            end
            S_HEAD_CHK:
            begin
                state_next = ((op_reg == OP_ROTATE) && take_now) ? S_HEAD_RD : S_OUT;
            end
            S_OUT:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath controls and register updates for each sequencer state.
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        pops_next      = pops_reg;
        op_next        = op_reg;
        stat_next      = stat_reg;
        key_next       = key_reg;
        new_next       = new_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_waddr      = head_reg;
        mem_wdata      = rd_entry;
        mem_re         = 1'b0;
        mem_raddr      = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = req.op;
                    key_next       = {req.hour, req.minute};
                    new_next       = '{hour: req.hour, minute: req.minute,
                                       command: req.command_id, level: req.log_level};
                    pos_next       = '0;
                    idx_next       = count_reg;
                    pops_next      = '0;
                    stat_next      = STAT_OK;
                    res_next       = '{status: STAT_EMPTY, default: '0};
                    if ((req.op == OP_INSERT) && (count_reg == CNT_W'(DEPTH)))
                    begin
                        stat_next = STAT_FULL;
                    end
                end
            end
            S_SCAN_RD:
            begin
                mem_re    = (pos_reg != count_reg);
                mem_raddr = ring_add(head_reg, pos_reg);
            end
            S_SCAN_CMP:
            begin
                if (key_reg > entry_key(rd_entry))
                begin
                    pos_next = pos_reg + CNT_W'(1);
                end
            end
            S_SHIFT_RD:
            begin
                mem_re    = (idx_reg > pos_reg);
                mem_raddr = ring_add(head_reg, idx_reg - CNT_W'(1));
            end
            S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ring_add(head_reg, idx_reg);
                mem_wdata = rd_entry;
                idx_next  = idx_reg - CNT_W'(1);
            end
            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ring_add(head_reg, pos_reg);
                mem_wdata  = new_reg;
                count_next = count_reg + CNT_W'(1);
            end
            S_HEAD_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = head_reg;
            end
            S_HEAD_CHK:
            begin
                // The read data is the current head; it is the result, replaced if a rotate checks the next head.
                res_next = '{status: stat_reg, task_hour: rd_entry.hour,
                             task_minute: rd_entry.minute, task_command: rd_entry.command,
                             task_level: rd_entry.level};
                if (((op_reg == OP_TAKE) && (count_reg >= CNT_W'(2))) ||
                    ((op_reg == OP_ROTATE) && take_now))
                begin
                    // Copy the head to the tail slot and advance the head.
                    mem_we    = 1'b1;
                    mem_waddr = ring_add(head_reg, count_reg);
                    mem_wdata = rd_entry;
                    head_next = ring_add(head_reg, CNT_W'(1));
                    pops_next = pops_reg + CNT_W'(1);
                end
            end
            S_OUT:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            pops_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            pops_reg      <= pops_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        stat_reg <= stat_next;
        key_reg  <= key_next;
        new_reg  <= new_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

endmodule
